// ===== hdl/peak_fraction_width_finder_unit_macros.svh =====
// assertion macros for the peak fraction width finder
// used by peak_fraction_width_finder_unit, no other dependencies
`ifndef PEAK_FRACTION_WIDTH_FINDER_UNIT_MACROS_SVH
`define PEAK_FRACTION_WIDTH_FINDER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PFWF_ASSERT_NOW(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PFWF_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/pfwf_pkg.sv =====
// shared constants for the peak fraction width finder
// no dependencies
`timescale 1ns / 1ps

package pfwf_pkg;

    localparam int MAX_BINS_DEF = 1024;
    localparam int MIN_SPAN_DEF = 5;

    localparam int COUNT_W    = 32;
    localparam int FRAC_W     = 17;
    localparam int THR_W      = COUNT_W + FRAC_W;
    localparam int IDX_OUT_W  = 10;
    localparam int OUT_DATA_W = 64;

    localparam logic [FRAC_W-1:0] FRAC_ONE     = 17'd65536;
    localparam logic [FRAC_W-1:0] FRAC_DEFAULT = 17'd32768;

    // apb register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_FRACTION = 1'b0;

endpackage

// ===== hdl/peak_fraction_width_finder_unit.sv =====
// peak fraction width finder: histogram load, peak tracking and threshold walk
// depends on pfwf_pkg and peak_fraction_width_finder_unit_macros.svh
`timescale 1ns / 1ps

// Takes one histogram bin count per cycle on the slave stream while loading
// (tlast marks the final bin), storing the counts in a single-port-write,
// single-port-read bin memory and tracking the first bin with the largest
// count. Bins beyond MAX_BINS are dropped. On the final bin the block forms
// the threshold fraction * peak in a 17 x 32 multiplier (state ST_MUL), then
// walks left and then right from the peak through the bin memory, with a read
// state and a compare state per bin visited, since each compare needs the
// registered read data. The input is held off from the final bin until the
// result is issued. If right - left is below MIN_SPAN both edges collapse to
// the peak bin. One result transaction comes out per histogram and waits in an
// output register, so loading of the next histogram may start while it waits.
// The fraction register lies at byte address 0 of the apb port (unsigned
// Q1.16, 65536 is one, reset one half; values above one act as one half).
// No clearing pass: only bins written for the current histogram are read.
module peak_fraction_width_finder_unit #(
    parameter int MAX_BINS = pfwf_pkg::MAX_BINS_DEF,
    parameter int MIN_SPAN = pfwf_pkg::MIN_SPAN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream, tdata: bin_count[31:0]; tlast: last_bin
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pfwf_pkg::COUNT_W-1:0]      s_axis_tdata,
    input  logic                              s_axis_tlast,
    // master stream, tdata: left_index[9:0], right_index[19:10],
    // peak_height[51:20], peak_index[61:52], zero fill [63:62]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pfwf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfwf_pkg::APB_AW-1:0]       paddr,
    input  logic [pfwf_pkg::APB_DW-1:0]       pwdata,
    output logic [pfwf_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int IW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MUL,
        ST_L_RD,
        ST_L_CHK,
        ST_R_RD,
        ST_R_CHK,
        ST_FIN
    } t_state;

    // bin memory
    logic [pfwf_pkg::COUNT_W-1:0] r_mem [MAX_BINS];
    logic [pfwf_pkg::COUNT_W-1:0] r_rd_data;
    logic                         mem_wr_en;
    logic [IW-1:0]                mem_wr_addr;
    logic                         mem_rd_en;
    logic [IW-1:0]                mem_rd_addr;

    // control and payload registers
    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_loaded, n_loaded;
    logic [CW-1:0]                   r_n, n_n;
    logic [pfwf_pkg::COUNT_W-1:0]    r_best_h, n_best_h;
    logic [IW-1:0]                   r_best_idx, n_best_idx;
    logic [IW-1:0]                   r_left, n_left;
    logic [IW-1:0]                   r_right, n_right;
    logic [pfwf_pkg::THR_W-1:0]      r_thr, n_thr;
    logic [pfwf_pkg::FRAC_W-1:0]     r_frac, n_frac;
    logic                            r_out_valid, n_out_valid;
    logic [pfwf_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                         in_fire;
    logic                         room;
    logic                         better;
    logic [pfwf_pkg::FRAC_W-1:0]  frac_eff;
    logic                         below;
    logic [CW-1:0]                right_next;
    logic [IW-1:0]                span;
    logic                         collapse;
    logic [IW-1:0]                fin_left;
    logic [IW-1:0]                fin_right;
    logic                         cfg_wr;

    // apb: always ready, one register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == pfwf_pkg::REG_FRACTION);
    assign prdata = (paddr[2] == pfwf_pkg::REG_FRACTION)
                    ? pfwf_pkg::APB_DW'(r_frac) : '0;

    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign room    = r_loaded < CW'(MAX_BINS);
    assign better  = (r_loaded == '0) || (s_axis_tdata > r_best_h);

    // fractions above one fall back to one half
    assign frac_eff = (r_frac > pfwf_pkg::FRAC_ONE) ? pfwf_pkg::FRAC_DEFAULT : r_frac;

    // exact compare: count * 65536 < fraction * peak
    assign below = {1'b0, r_rd_data, 16'h0000} < r_thr;

    assign right_next = CW'(r_right) + CW'(1);

    assign span     = r_right - r_left;
    assign collapse = 32'(span) < 32'(MIN_SPAN);
    assign fin_left  = collapse ? r_best_idx : r_left;
    assign fin_right = collapse ? r_best_idx : r_right;

    assign mem_wr_en   = in_fire && room;
    assign mem_wr_addr = r_loaded[IW-1:0];

    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_n         = r_n;
        n_best_h    = r_best_h;
        n_best_idx  = r_best_idx;
        n_left      = r_left;
        n_right     = r_right;
        n_thr       = r_thr;
        n_frac      = r_frac;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;

        if (cfg_wr) begin
            n_frac = pwdata[pfwf_pkg::FRAC_W-1:0];
        end

        case (r_state)
            ST_LOAD: begin
                if (in_fire) begin
                    if (room) begin
                        n_loaded = r_loaded + CW'(1);
                        if (better) begin
                            n_best_h   = s_axis_tdata;
                            n_best_idx = r_loaded[IW-1:0];
                        end
                    end
                    if (s_axis_tlast) begin
                        n_n     = room ? r_loaded + CW'(1) : r_loaded;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // full-width product, both operands widened first
                n_thr   = pfwf_pkg::THR_W'(frac_eff) * pfwf_pkg::THR_W'(r_best_h);
                n_left  = r_best_idx;
                n_right = r_best_idx;
                n_state = ST_L_RD;
            end
            ST_L_RD: begin
                if (r_left == '0) begin
                    n_state = ST_R_RD;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_left - IW'(1);
                    n_state     = ST_L_CHK;
                end
            end
            ST_L_CHK: begin
                if (!below) begin
                    n_left  = r_left - IW'(1);
                    n_state = ST_L_RD;
                end else begin
                    n_state = ST_R_RD;
                end
            end
            ST_R_RD: begin
                if (right_next >= r_n) begin
                    n_state = ST_FIN;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_right + IW'(1);
                    n_state     = ST_R_CHK;
                end
            end
            ST_R_CHK: begin
                if (!below) begin
                    n_right = r_right + IW'(1);
                    n_state = ST_R_RD;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00,
                                   pfwf_pkg::IDX_OUT_W'(r_best_idx),
                                   r_best_h,
                                   pfwf_pkg::IDX_OUT_W'(fin_right),
                                   pfwf_pkg::IDX_OUT_W'(fin_left)};
                    n_loaded    = '0;
                    n_best_h    = '0;
                    n_best_idx  = '0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_loaded    <= '0;
            r_best_h    <= '0;
            r_best_idx  <= '0;
            r_frac      <= pfwf_pkg::FRAC_DEFAULT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_best_h    <= n_best_h;
            r_best_idx  <= n_best_idx;
            r_frac      <= n_frac;
            r_out_valid <= n_out_valid;
        end
        r_n        <= n_n;
        r_left     <= n_left;
        r_right    <= n_right;
        r_thr      <= n_thr;
        r_out_data <= n_out_data;
    end

    // bin memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd_en) begin
            r_rd_data <= r_mem[mem_rd_addr];
        end
    end

`include "peak_fraction_width_finder_unit_macros.svh"

    `PFWF_ASSERT_NOW(a_loaded_bound, i_clk, i_rst_n, 1'b1, r_loaded <= CW'(MAX_BINS), "bin count overran the memory")
    `PFWF_ASSERT_NOW(a_walk_brackets_peak, i_clk, i_rst_n, (r_state == ST_L_RD) || (r_state == ST_L_CHK) || (r_state == ST_R_RD) || (r_state == ST_R_CHK), (r_left <= r_best_idx) && (r_right >= r_best_idx), "walk edges do not bracket the peak")
    `PFWF_ASSERT_NOW(a_right_read_in_range, i_clk, i_rst_n, r_state == ST_R_CHK, right_next < r_n, "right walk read past the loaded bins")
    `PFWF_ASSERT_NEXT(a_result_issued, i_clk, i_rst_n, (r_state == ST_FIN) && (!r_out_valid || m_axis_tready), m_axis_tvalid && (r_state == ST_LOAD) && (r_loaded == '0), "finish did not issue a result and clear the histogram")

endmodule

// ===== tb/peak_fraction_width_finder_unit_tb.sv =====
// self-checking testbench for the peak fraction width finder: histograms in, peak ranges out
// depends on pfwf_pkg and peak_fraction_width_finder_unit, nothing else
`timescale 1ns / 1ps

module peak_fraction_width_finder_unit_tb;

    // run limit in clock cycles, far above the slowest legal run
    localparam longint unsigned CYCLE_LIMIT = 600000;
    // byte address of the fraction register on the apb port
    localparam logic [pfwf_pkg::APB_AW-1:0] FRACTION_ADDR =
        pfwf_pkg::APB_AW'(4 * pfwf_pkg::REG_FRACTION);
    // idle cycles allowed after the last result before the block counts as quiet
    localparam int QUIET_CYCLES = 24;

    // one peak range as the block reports it
    typedef struct packed {
        logic [pfwf_pkg::IDX_OUT_W-1:0] lo_edge;
        logic [pfwf_pkg::IDX_OUT_W-1:0] hi_edge;
        logic [pfwf_pkg::COUNT_W-1:0]   height;
        logic [pfwf_pkg::IDX_OUT_W-1:0] peak_idx;
    } t_span_result;

    // one row of the directed table: a bin and, where obvious, the range it closes
    typedef struct packed {
        logic [pfwf_pkg::COUNT_W-1:0] count;
        logic                         last;
        logic                         typed;
        t_span_result                 want;
    } t_dir_row;

    // histogram shapes for the random part
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_BELL,
        SHAPE_TINY,
        SHAPE_FLAT,
        SHAPE_HALF
    } t_shape;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [pfwf_pkg::COUNT_W-1:0]    s_axis_tdata;   // bin_count[31:0]
    logic                            s_axis_tlast;   // last_bin
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // left_index[9:0], right_index[19:10], peak_height[51:20], peak_index[61:52], zero [63:62]
    logic [pfwf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [pfwf_pkg::APB_AW-1:0]     paddr;
    logic [pfwf_pkg::APB_DW-1:0]     pwdata;
    logic [pfwf_pkg::APB_DW-1:0]     prdata;
    logic                            pready;

    peak_fraction_width_finder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow of the block: bins of the open histogram, running maximum, fraction
    logic [pfwf_pkg::COUNT_W-1:0] hist_bins [0:pfwf_pkg::MAX_BINS_DEF-1];
    int unsigned                  hist_len;
    logic [pfwf_pkg::COUNT_W-1:0] top_height;
    int unsigned                  top_index;
    logic [pfwf_pkg::FRAC_W-1:0]  frac_q16;

    // ranges still owed by the block, oldest first
    t_span_result       owed_spans [$];

    int unsigned        err_count   = 0;
    int unsigned        spans_seen  = 0;
    int unsigned        tx_pace     = 1;
    longint unsigned    cycle_count = 0;
    int unsigned        frac_plan [8];

    // directed histograms, all run at the reset fraction of one half
    t_dir_row dir_rows [20] = '{
        // single bin at full scale closes at once
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{10'd0, 10'd0, 32'hFFFF_FFFF, 10'd0}},
        // all zero: peak is bin 0, the right walk covers every bin, span of five stays
        '{32'd0, 1'b0, 1'b0, '0},
        '{32'd0, 1'b0, 1'b0, '0},
        '{32'd0, 1'b0, 1'b0, '0},
        '{32'd0, 1'b0, 1'b0, '0},
        '{32'd0, 1'b0, 1'b0, '0},
        '{32'd0, 1'b1, 1'b1, '{10'd0, 10'd5, 32'd0, 10'd0}},
        // flat run of five bins: span four is too narrow, range collapses on bin 0
        '{32'd7, 1'b0, 1'b0, '0},
        '{32'd7, 1'b0, 1'b0, '0},
        '{32'd7, 1'b0, 1'b0, '0},
        '{32'd7, 1'b0, 1'b0, '0},
        '{32'd7, 1'b1, 1'b1, '{10'd0, 10'd0, 32'd7, 10'd0}},
        // tied plateau: first maximum wins, walks stop on the low shoulders
        '{32'd1, 1'b0, 1'b0, '0},
        '{32'd9, 1'b0, 1'b0, '0},
        '{32'd9, 1'b0, 1'b0, '0},
        '{32'd9, 1'b0, 1'b0, '0},
        '{32'd9, 1'b0, 1'b0, '0},
        '{32'd9, 1'b0, 1'b0, '0},
        '{32'd9, 1'b0, 1'b0, '0},
        '{32'd2, 1'b1, 1'b0, '0}
    };

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d ranges owed", cycle_count,
                     owed_spans.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic flag_error(input string what);
        if (err_count < 10)
            $display("%s", what);
        err_count++;
    endtask

    // shadow update for one accepted bin; returns 1 when it closes a histogram
    function automatic bit predict_span(input logic [pfwf_pkg::COUNT_W-1:0] count,
                                        input logic last, output t_span_result res);
        logic [pfwf_pkg::FRAC_W-1:0] frac_eff;
        longint unsigned             thr;
        int unsigned                 lo;
        int unsigned                 hi;
        res = '0;
        // bins past the store size are dropped outright
        if (hist_len < pfwf_pkg::MAX_BINS_DEF) begin
            hist_bins[hist_len] = count;
            if (hist_len == 0 || count > top_height) begin
                top_height = count;
                top_index  = hist_len;
            end
            hist_len++;
        end
        if (!last)
            return 1'b0;
        // fractions above one fall back to one half
        frac_eff = (frac_q16 > pfwf_pkg::FRAC_ONE) ? pfwf_pkg::FRAC_DEFAULT : frac_q16;
        thr      = 64'(frac_eff) * 64'(top_height);
        lo = top_index;
        while (lo > 0 && (64'(hist_bins[lo-1]) << 16) >= thr)
            lo--;
        hi = top_index;
        while (hi + 1 < hist_len && (64'(hist_bins[hi+1]) << 16) >= thr)
            hi++;
        if (hi - lo < pfwf_pkg::MIN_SPAN_DEF) begin
            lo = top_index;
            hi = top_index;
        end
        res.lo_edge  = pfwf_pkg::IDX_OUT_W'(lo);
        res.hi_edge  = pfwf_pkg::IDX_OUT_W'(hi);
        res.height   = top_height;
        res.peak_idx = pfwf_pkg::IDX_OUT_W'(top_index);
        hist_len   = 0;
        top_height = '0;
        top_index  = 0;
        return 1'b1;
    endfunction

    // push one bin through the slave stream after a random gap
    task automatic send_bin(input logic [pfwf_pkg::COUNT_W-1:0] count, input logic last,
                            input logic typed, input t_span_result want);
        int unsigned  gap;
        t_span_result res;
        gap = (tx_pace == 0) ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= count;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        // transaction taken at this edge
        if (predict_span(count, last, res))
            owed_spans.push_back(typed ? want : res);
    endtask

    // hold the sender until every owed range is out and the block has settled
    task automatic hold_until_quiet();
        s_axis_tvalid <= 1'b0;
        while (owed_spans.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_read(output logic [pfwf_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= FRACTION_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        value   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write the fraction, mirror it in the shadow and read it back
    task automatic set_fraction(input logic [pfwf_pkg::APB_DW-1:0] value);
        logic [pfwf_pkg::APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FRACTION_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frac_q16 = value[pfwf_pkg::FRAC_W-1:0];
        // let the bus go idle between the write and the readback
        @(posedge i_clk);
        apb_read(rd);
        if (rd !== pfwf_pkg::APB_DW'(frac_q16))
            flag_error($sformatf("fraction readback: expected %0d got %0d", frac_q16, rd));
    endtask

    // one random histogram of the given shape
    task automatic send_histogram(input int unsigned n_bins, input t_shape shape);
        logic [pfwf_pkg::COUNT_W-1:0] peak_val;
        logic [pfwf_pkg::COUNT_W-1:0] v;
        longint unsigned              step;
        longint unsigned              dip;
        int unsigned                  peak_pos;
        int unsigned                  from_peak;
        peak_val = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom;
        if (peak_val < 2)
            peak_val = 2;
        step     = 64'(peak_val) / $urandom_range(2, 12);
        peak_pos = $urandom_range(0, n_bins - 1);
        for (int i = 0; i < n_bins; i++) begin
            from_peak = (i > peak_pos) ? i - peak_pos : peak_pos - i;
            case (shape)
                SHAPE_NOISE: v = $urandom;
                SHAPE_BELL: begin
                    // falling shoulders with jitter so the threshold lands anywhere
                    dip = from_peak * step
                          + ((from_peak != 0) ? $urandom_range(0, 32'(step)) : 0);
                    v   = (dip >= peak_val) ? '0 : peak_val - pfwf_pkg::COUNT_W'(dip);
                end
                SHAPE_TINY: v = $urandom_range(0, 3);
                SHAPE_FLAT: v = peak_val;
                default: begin
                    // shoulders within one count of exactly half the peak
                    v = (i == peak_pos) ? peak_val
                                        : (peak_val >> 1) - 1 + $urandom_range(0, 2);
                end
            endcase
            send_bin(v, i == n_bins - 1, 1'b0, '0);
        end
    endtask

    // compare one result transaction with the oldest owed range
    task automatic check_span(input logic [pfwf_pkg::OUT_DATA_W-1:0] beat);
        t_span_result want;
        if (owed_spans.size() == 0) begin
            flag_error($sformatf("unexpected result 0x%016h", beat));
            return;
        end
        want = owed_spans.pop_front();
        if (beat[9:0] !== want.lo_edge || beat[19:10] !== want.hi_edge ||
            beat[51:20] !== want.height || beat[61:52] !== want.peak_idx ||
            beat[63:62] !== 2'b00)
            flag_error($sformatf(
                "range mismatch: expected l=%0d r=%0d h=%0d p=%0d, got l=%0d r=%0d h=%0d p=%0d fill=%b",
                want.lo_edge, want.hi_edge, want.height, want.peak_idx,
                beat[9:0], beat[19:10], beat[51:20], beat[61:52], beat[63:62]));
    endtask

    // result side: random stall per transaction, calm stretches now and then
    initial begin
        int unsigned stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = (((spans_seen / 8) % 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            check_span(m_axis_tdata);
            spans_seen++;
        end
    end

    initial begin
        logic [pfwf_pkg::APB_DW-1:0] rd;
        int unsigned                 n_sent;
        int unsigned                 pick;
        t_shape                      shape;
        int unsigned                 n_bins;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        hist_len   = 0;
        top_height = '0;
        top_index  = 0;
        frac_q16   = pfwf_pkg::FRAC_DEFAULT;

        // fraction settings per phase: extremes, the out-of-range fallback, one random
        frac_plan = '{0, 65536, 131071, 65535, 1, 65537, 0, 32768};
        frac_plan[6] = $urandom_range(2, 65534);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fraction must come up as one half
        apb_read(rd);
        if (rd !== pfwf_pkg::APB_DW'(pfwf_pkg::FRAC_DEFAULT))
            flag_error($sformatf("fraction after reset: expected %0d got %0d",
                                 pfwf_pkg::FRAC_DEFAULT, rd));

        // directed table
        tx_pace = $urandom_range(0, 3);
        foreach (dir_rows[i])
            send_bin(dir_rows[i].count, dir_rows[i].last, dir_rows[i].typed,
                     dir_rows[i].want);
        hold_until_quiet();

        // random phases, each under its own fraction, written only while idle
        for (int p = 0; p < 8; p++) begin
            set_fraction(frac_plan[p]);
            n_sent = 0;
            while (n_sent < 55) begin
                tx_pace = $urandom_range(0, 3);
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    shape = SHAPE_BELL;
                else if (pick == 5)
                    shape = SHAPE_FLAT;
                else if (pick == 6)
                    shape = SHAPE_HALF;
                else if (pick == 7)
                    shape = SHAPE_TINY;
                else
                    shape = SHAPE_NOISE;
                // mostly mid-sized, some narrow enough to force a collapse
                n_bins = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4)
                                                      : $urandom_range(5, 20);
                send_histogram(n_bins, shape);
                n_sent += n_bins;
                // sometimes let the block drain completely mid-phase
                if ($urandom_range(0, 5) == 0)
                    hold_until_quiet();
            end
            if (p == 7) begin
                // overlong histogram: wide shoulders reach both store edges, and the
                // three bins past the store are huge but must be ignored, the final
                // one still closing the histogram
                tx_pace = 0;
                for (int i = 0; i < pfwf_pkg::MAX_BINS_DEF + 3; i++) begin
                    if (i >= pfwf_pkg::MAX_BINS_DEF)
                        send_bin(32'hFFFF_FFFF, i == pfwf_pkg::MAX_BINS_DEF + 2,
                                 1'b0, '0);
                    else
                        send_bin(32'h4000_0000
                                 - pfwf_pkg::COUNT_W'(((i > 900) ? i - 900 : 900 - i)
                                                      * 32'h0008_0000)
                                 - $urandom_range(0, 255),
                                 1'b0, 1'b0, '0);
                end
            end
            hold_until_quiet();
        end

        // settle, then judge
        repeat (QUIET_CYCLES) @(posedge i_clk);
        if (owed_spans.size() != 0)
            flag_error($sformatf("%0d ranges never arrived", owed_spans.size()));
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pfwf_pkg.sv
hdl/peak_fraction_width_finder_unit.sv
tb/peak_fraction_width_finder_unit_tb.sv
